/* rtl/core/i2c_bit_level_master_top_macros.svh */
// assertion macros shared by the i2c bit-level master rtl
// no dependencies; expects signals clk and rst in the including module
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2cbm_pkg.sv */
// shared types and constants for the i2c bit-level master
// no dependencies
`default_nettype none

package i2cbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [3:0] BYTE_BITS = 4'(BITS_PER_BYTE);
  localparam int MSB_IDX = BITS_PER_BYTE - 1;

  // register reset values
  localparam logic [7:0] LONG_DELAY_RESET  = 8'd5;
  localparam logic [7:0] SHORT_DELAY_RESET = 8'd1;
  localparam logic [7:0] POLL_LIMIT_RESET  = 8'd250;

  // configuration register indexes
  localparam logic [1:0] CFG_LONG_DELAY  = 2'd0;
  localparam logic [1:0] CFG_SHORT_DELAY = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_READ  = 3'd3,
    ACT_STOP  = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_W_SETUP = 4'd4,
    PH_W_HIGH  = 4'd5,
    PH_W_AFTER = 4'd6,
    PH_A_REL   = 4'd7,
    PH_A_HIGH  = 4'd8,
    PH_POLL    = 4'd9,
    PH_R_HIGH  = 4'd10,
    PH_R_LOW   = 4'd11,
    PH_K_SETUP = 4'd12,
    PH_K_HIGH  = 4'd13,
    PH_K_LOW   = 4'd14
  } phase_t;

  typedef struct packed {
    logic [7:0] long_delay_ticks;
    logic [7:0] short_delay_ticks;
    logic [7:0] ack_poll_limit;
  } i2cbm_cfg_t;

  typedef struct packed {
    logic       nack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } i2cbm_res_t;

  // a zero hold count acts as one tick
  function automatic logic [7:0] hold_ticks(input logic [7:0] d);
    hold_ticks = (d == 8'd0) ? 8'd1 : d;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/i2cbm_cfg.sv */
// configuration registers of the i2c bit-level master
// depends on i2cbm_pkg
`default_nettype none

module i2cbm_cfg
  import i2cbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [1:0] wr_index,
  input  wire logic [7:0] wr_data,
  output i2cbm_cfg_t      cfg
);

  // register write, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_delay_ticks  <= LONG_DELAY_RESET;
      cfg.short_delay_ticks <= SHORT_DELAY_RESET;
      cfg.ack_poll_limit    <= POLL_LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_LONG_DELAY:  cfg.long_delay_ticks  <= wr_data;
        CFG_SHORT_DELAY: cfg.short_delay_ticks <= wr_data;
        CFG_POLL_LIMIT:  cfg.ack_poll_limit    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/i2cbm_seq.sv */
// bit sequencer: one tick per call, drives scl/sda and tracks the byte
// depends on i2cbm_pkg and the assertion macro header
`default_nettype none

`include "i2c_bit_level_master_top_macros.svh"

module i2cbm_seq
  import i2cbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [2:0] action,
  input  wire logic [7:0] tx_byte,
  input  wire logic       send_ack,
  input  wire logic       sda_in,
  input  wire i2cbm_cfg_t cfg,
  output i2cbm_res_t      res
);

  phase_t     phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] delay_count, delay_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic       ack_choice, ack_choice_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       nack_flag, nack_flag_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       done;

  // shared decode
  logic       cmd_valid;
  logic       timed_end;
  logic       polling;
  logic [7:0] poll_base;
  logic       poll_over;
  logic [3:0] bit_inc;
  logic [7:0] shift_left;

  assign cmd_valid  = (action == ACT_START) || (action == ACT_WRITE) ||
                      (action == ACT_READ)  || (action == ACT_STOP);
  assign timed_end  = (phase != PH_IDLE) && (phase != PH_POLL) && (delay_count <= 8'd1);
  assign polling    = (phase == PH_POLL) || (timed_end && (phase == PH_A_HIGH));
  assign poll_base  = (phase == PH_A_HIGH) ? 8'd0 : poll_count;
  assign poll_over  = poll_base >= cfg.ack_poll_limit;
  assign bit_inc    = bit_index + 4'd1;
  assign shift_left = {shift_reg[MSB_IDX-1:0], 1'b0};

  // next phase
  always_comb begin
    phase_next = phase;
    if (phase == PH_IDLE) begin
      case (action)
        ACT_START: phase_next = PH_ST_A;
        ACT_WRITE: phase_next = PH_W_SETUP;
        ACT_READ:  phase_next = PH_R_HIGH;
        ACT_STOP:  phase_next = PH_SP_A;
        default:   phase_next = PH_IDLE;
      endcase
    end else if (polling) begin
      phase_next = (!sda_in || poll_over) ? PH_IDLE : PH_POLL;
    end else if (timed_end) begin
      case (phase)
        PH_ST_A:    phase_next = PH_ST_B;
        PH_ST_B:    phase_next = PH_IDLE;
        PH_SP_A:    phase_next = PH_IDLE;
        PH_W_SETUP: phase_next = PH_W_HIGH;
        PH_W_HIGH:  phase_next = PH_W_AFTER;
        PH_W_AFTER: phase_next = (bit_inc < BYTE_BITS) ? PH_W_SETUP : PH_A_REL;
        PH_A_REL:   phase_next = PH_A_HIGH;
        PH_R_HIGH:  phase_next = PH_R_LOW;
        PH_R_LOW:   phase_next = (bit_inc < BYTE_BITS) ? PH_R_HIGH : PH_K_SETUP;
        PH_K_SETUP: phase_next = PH_K_HIGH;
        PH_K_HIGH:  phase_next = PH_K_LOW;
        PH_K_LOW:   phase_next = PH_IDLE;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath and line levels
  always_comb begin
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    ack_choice_next  = ack_choice;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    nack_flag_next   = nack_flag;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    if (phase == PH_IDLE) begin
      case (action)
        ACT_START: begin
          sda_level_next   = 1'b1;
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        ACT_WRITE: begin
          shift_reg_next   = tx_byte;
          bit_index_next   = 4'd0;
          poll_count_next  = 8'd0;
          scl_level_next   = 1'b0;
          sda_level_next   = tx_byte[MSB_IDX];
          delay_count_next = hold_ticks(cfg.short_delay_ticks);
        end
        ACT_READ: begin
          shift_reg_next   = 8'd0;
          bit_index_next   = 4'd0;
          ack_choice_next  = send_ack;
          sda_level_next   = 1'b1;
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        ACT_STOP: begin
          sda_level_next   = 1'b0;
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        default: ;
      endcase
    end else if (polling) begin
      // ack check: low is ack, high once the poll count reaches the limit is nack
      if (!sda_in || poll_over) begin
        scl_level_next = 1'b0;
        nack_flag_next = sda_in;
        done           = 1'b1;
      end else begin
        poll_count_next = poll_base + 8'd1;
      end
    end else if (!timed_end) begin
      delay_count_next = delay_count - 8'd1;
    end else begin
      case (phase)
        PH_ST_A: begin
          sda_level_next   = 1'b0;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_ST_B: begin
          scl_level_next = 1'b0;
          done           = 1'b1;
        end
        PH_SP_A: begin
          sda_level_next = 1'b1;
          done           = 1'b1;
        end
        PH_W_SETUP: begin
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_W_HIGH: begin
          scl_level_next   = 1'b0;
          delay_count_next = hold_ticks(cfg.short_delay_ticks);
        end
        PH_W_AFTER: begin
          bit_index_next = bit_inc;
          shift_reg_next = shift_left;
          if (bit_inc < BYTE_BITS) begin
            sda_level_next   = shift_left[MSB_IDX];
            delay_count_next = hold_ticks(cfg.short_delay_ticks);
          end else begin
            sda_level_next   = 1'b1;
            delay_count_next = hold_ticks(cfg.long_delay_ticks);
          end
        end
        PH_A_REL: begin
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_R_HIGH: begin
          shift_reg_next   = {shift_reg[MSB_IDX-1:0], sda_in};
          scl_level_next   = 1'b0;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_R_LOW: begin
          bit_index_next = bit_inc;
          if (bit_inc < BYTE_BITS) begin
            scl_level_next = 1'b1;
          end else begin
            rx_hold_next   = shift_reg;
            sda_level_next = !ack_choice;
          end
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_K_SETUP: begin
          scl_level_next   = 1'b1;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_K_HIGH: begin
          scl_level_next   = 1'b0;
          delay_count_next = hold_ticks(cfg.long_delay_ticks);
        end
        PH_K_LOW: begin
          sda_level_next = 1'b1;
          done           = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // state registers, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 8'd0;
      poll_count  <= 8'd0;
      ack_choice  <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      nack_flag   <= 1'b0;
      rx_hold     <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      poll_count  <= poll_count_next;
      ack_choice  <= ack_choice_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      nack_flag   <= nack_flag_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // result of this tick, taken from the updated state
  always_comb begin
    res.scl_out  = scl_level_next;
    res.sda_out  = sda_level_next;
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.rx_byte  = rx_hold_next;
    res.nack     = nack_flag_next;
  end

  `I2CBM_ASSERT_NOW(a_hold_nonzero, (phase != PH_IDLE) && (phase != PH_POLL), delay_count != 8'd0, "timed step with zero hold count")
  `I2CBM_ASSERT_NOW(a_bit_range, 1'b1, bit_index <= BYTE_BITS, "bit index past the byte")
  `I2CBM_ASSERT_NOW(a_poll_scl_high, phase == PH_POLL, scl_level, "scl low while polling for ack")
  `I2CBM_ASSERT_NOW(a_done_ends, step && done, phase_next == PH_IDLE, "command done without returning idle")

endmodule

`default_nettype wire

/* rtl/core/i2c_bit_level_master_top.sv */
// i2c bit-level master: one timing tick per input beat, one result beat per tick.
// latency: the result beat for a tick is valid the cycle after the tick beat.
// throughput: one tick per cycle when no result is held, set by the single state update.
// the output register lets a new tick in while the last result is being taken.
// reset (rst, synchronous) idles the sequencer, releases scl/sda, loads register defaults.
// depends on i2cbm_pkg, i2cbm_cfg, i2cbm_seq and the assertion macro header
`default_nettype none

`include "i2c_bit_level_master_top_macros.svh"

module i2c_bit_level_master_top
  import i2cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // tick beats
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // action[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
  // result beats
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                      // rx_byte[11:4], nack[12]
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  i2cbm_cfg_t cfg;
  i2cbm_res_t res;
  i2cbm_res_t res_q;
  logic       step;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  i2cbm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2cbm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .action   (s_tdata[2:0]),
    .tx_byte  (s_tdata[10:3]),
    .send_ack (s_tdata[11]),
    .sda_in   (s_tdata[12]),
    .cfg      (cfg),
    .res      (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {3'b000, res_q};

  `I2CBM_ASSERT_NEXT(a_tick_gives_beat, step, m_tvalid, "accepted tick produced no result beat")
  `I2CBM_ASSERT_NOW(a_done_not_busy, m_tvalid && res_q.done_res, !res_q.busy_res, "done reported while still busy")
  `I2CBM_ASSERT_NEXT(a_stall_blocks, m_tvalid && !m_tready, !step || m_tready || !m_tvalid, "tick taken over a held result")

endmodule

`default_nettype wire

/* tb/tb_i2c_bit_level_master_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the tick-driven i2c bit-level master
// a directed table, then random start/write/read/stop sequences under several
// register settings and stall patterns; depends on i2cbm_pkg and the top rtl

module tb_i2c_bit_level_master_top;
  import i2cbm_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 80;
  localparam int LAT_PAD      = 4;
  localparam int PHASE_TICKS  = 80;
  localparam int DIR_ROWS     = 16;

  // action codes outside the command set, ignored when idle
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  // directed row: the tick, the action carried by the busy ticks that follow,
  // and an optional typed-in result for the tick itself
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
    logic [2:0] fill_act;
    logic       lit;
    i2cbm_res_t res;
  } dir_row_t;

  localparam i2cbm_res_t IDLE_RX00 = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b0, sda_out: 1'b1, scl_out: 1'b1};
  localparam i2cbm_res_t IDLE_RXFF = '{nack: 1'b0, rx_byte: 8'hFF, done_res: 1'b0,
                                       busy_res: 1'b0, sda_out: 1'b1, scl_out: 1'b1};
  localparam i2cbm_res_t START_GO  = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b1, scl_out: 1'b1};
  localparam i2cbm_res_t WR_MSB1   = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b1, scl_out: 1'b0};
  localparam i2cbm_res_t WR_MSB0_N = '{nack: 1'b1, rx_byte: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b0, scl_out: 1'b0};
  localparam i2cbm_res_t RD_RX00   = '{nack: 1'b0, rx_byte: 8'h00, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b1, scl_out: 1'b1};
  localparam i2cbm_res_t RD_RXFF   = '{nack: 1'b0, rx_byte: 8'hFF, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b1, scl_out: 1'b1};
  localparam i2cbm_res_t STOP_RXFF = '{nack: 1'b0, rx_byte: 8'hFF, done_res: 1'b0,
                                       busy_res: 1'b1, sda_out: 1'b0, scl_out: 1'b1};

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ACT_NONE,   8'h00, 1'b0, 1'b1, ACT_NONE,   1'b1, IDLE_RX00},
    '{ACT_SPARE5, 8'hFF, 1'b1, 1'b1, ACT_NONE,   1'b1, IDLE_RX00},
    '{ACT_SPARE6, 8'h00, 1'b1, 1'b0, ACT_NONE,   1'b1, IDLE_RX00},
    '{ACT_SPARE7, 8'hAA, 1'b0, 1'b1, ACT_NONE,   1'b1, IDLE_RX00},
    '{ACT_START,  8'h55, 1'b1, 1'b1, ACT_WRITE,  1'b1, START_GO},
    '{ACT_WRITE,  8'hFF, 1'b0, 1'b1, ACT_NONE,   1'b1, WR_MSB1},
    '{ACT_WRITE,  8'h00, 1'b1, 1'b0, ACT_READ,   1'b1, WR_MSB0_N},
    '{ACT_WRITE,  8'h5A, 1'b0, 1'b0, ACT_SPARE7, 1'b0, '0},
    '{ACT_READ,   8'h00, 1'b1, 1'b1, ACT_STOP,   1'b1, RD_RX00},
    '{ACT_READ,   8'h00, 1'b0, 1'b0, ACT_NONE,   1'b1, RD_RXFF},
    '{ACT_READ,   8'h00, 1'b1, 1'b1, ACT_START,  1'b0, '0},
    '{ACT_STOP,   8'h00, 1'b0, 1'b1, ACT_START,  1'b1, STOP_RXFF},
    '{ACT_NONE,   8'h00, 1'b0, 1'b0, ACT_NONE,   1'b1, IDLE_RXFF},
    '{ACT_START,  8'h00, 1'b0, 1'b1, ACT_READ,   1'b0, '0},
    '{ACT_WRITE,  8'h81, 1'b0, 1'b0, ACT_NONE,   1'b0, '0},
    '{ACT_STOP,   8'hFF, 1'b1, 1'b1, ACT_WRITE,  1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // predicted master state and register copies
  phase_t     mst_phase;
  logic [3:0] mst_bit;
  logic [7:0] mst_shift;
  logic [7:0] mst_delay;
  logic [7:0] mst_polls;
  logic [7:0] mst_rx;
  logic       mst_ack_sel;
  logic       mst_scl;
  logic       mst_sda;
  logic       mst_nack;
  logic [7:0] cfg_long;
  logic [7:0] cfg_short;
  logic [7:0] cfg_limit;

  i2cbm_res_t predicted_q[$];
  i2cbm_res_t seen_res;
  i2cbm_res_t want_res;
  int         mismatch_count = 0;
  int         work_ticks = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         cycle_count;
  int         hold_count;
  logic       hold_req = 1'b0;

  always #10 clk = ~clk;

  i2c_bit_level_master_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // enter a timed step, a zero count holds for one tick
  function automatic void hold_step(phase_t ph, logic [7:0] d);
    mst_phase = ph;
    mst_delay = (d == 8'd0) ? 8'd1 : d;
  endfunction

  // one sample of the acknowledge check, returns 1 when the write finishes
  function automatic bit poll_sample(logic sda);
    if (!sda) begin
      mst_scl   = 1'b0;
      mst_nack  = 1'b0;
      mst_phase = PH_IDLE;
      return 1'b1;
    end
    if (mst_polls >= cfg_limit) begin
      mst_scl   = 1'b0;
      mst_nack  = 1'b1;
      mst_phase = PH_IDLE;
      return 1'b1;
    end
    mst_polls = mst_polls + 8'd1;
    mst_phase = PH_POLL;
    return 1'b0;
  endfunction

  // step change once the hold has run out, returns 1 when the command finishes
  function automatic bit leave_step(logic sda);
    case (mst_phase)
      PH_ST_A: begin
        mst_sda = 1'b0;
        hold_step(PH_ST_B, cfg_long);
      end
      PH_ST_B: begin
        mst_scl   = 1'b0;
        mst_phase = PH_IDLE;
        return 1'b1;
      end
      PH_SP_A: begin
        mst_sda   = 1'b1;
        mst_phase = PH_IDLE;
        return 1'b1;
      end
      PH_W_SETUP: begin
        mst_scl = 1'b1;
        hold_step(PH_W_HIGH, cfg_long);
      end
      PH_W_HIGH: begin
        mst_scl = 1'b0;
        hold_step(PH_W_AFTER, cfg_short);
      end
      PH_W_AFTER: begin
        mst_bit   = mst_bit + 4'd1;
        mst_shift = mst_shift << 1;
        if (mst_bit < BYTE_BITS) begin
          mst_sda = mst_shift[MSB_IDX];
          hold_step(PH_W_SETUP, cfg_short);
        end else begin
          mst_sda = 1'b1;
          hold_step(PH_A_REL, cfg_long);
        end
      end
      PH_A_REL: begin
        mst_scl = 1'b1;
        hold_step(PH_A_HIGH, cfg_long);
      end
      PH_A_HIGH: begin
        mst_polls = 8'd0;
        return poll_sample(sda);
      end
      PH_POLL: return poll_sample(sda);
      PH_R_HIGH: begin
        mst_shift = {mst_shift[6:0], sda};
        mst_scl   = 1'b0;
        hold_step(PH_R_LOW, cfg_long);
      end
      PH_R_LOW: begin
        mst_bit = mst_bit + 4'd1;
        if (mst_bit < BYTE_BITS) begin
          mst_scl = 1'b1;
          hold_step(PH_R_HIGH, cfg_long);
        end else begin
          mst_rx  = mst_shift;
          mst_sda = ~mst_ack_sel;
          hold_step(PH_K_SETUP, cfg_long);
        end
      end
      PH_K_SETUP: begin
        mst_scl = 1'b1;
        hold_step(PH_K_HIGH, cfg_long);
      end
      PH_K_HIGH: begin
        mst_scl = 1'b0;
        hold_step(PH_K_LOW, cfg_long);
      end
      PH_K_LOW: begin
        mst_sda   = 1'b1;
        mst_phase = PH_IDLE;
        return 1'b1;
      end
      default: mst_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // one tick of the master: new state and the line/status beat it yields
  function automatic i2cbm_res_t master_tick(logic [2:0] act, logic [7:0] tx, logic ack,
                                             logic sda);
    bit         fin;
    i2cbm_res_t r;
    fin = 1'b0;
    if (mst_phase == PH_IDLE) begin
      case (act)
        ACT_START: begin
          mst_sda = 1'b1;
          mst_scl = 1'b1;
          hold_step(PH_ST_A, cfg_long);
        end
        ACT_WRITE: begin
          mst_shift = tx;
          mst_bit   = 4'd0;
          mst_polls = 8'd0;
          mst_scl   = 1'b0;
          mst_sda   = tx[MSB_IDX];
          hold_step(PH_W_SETUP, cfg_short);
        end
        ACT_READ: begin
          mst_shift   = 8'd0;
          mst_bit     = 4'd0;
          mst_ack_sel = ack;
          mst_sda     = 1'b1;
          mst_scl     = 1'b1;
          hold_step(PH_R_HIGH, cfg_long);
        end
        ACT_STOP: begin
          mst_sda = 1'b0;
          mst_scl = 1'b1;
          hold_step(PH_SP_A, cfg_long);
        end
        default: ;
      endcase
    end else if (mst_phase == PH_POLL) begin
      fin = poll_sample(sda);
    end else if (mst_delay > 8'd1) begin
      mst_delay = mst_delay - 8'd1;
    end else begin
      fin = leave_step(sda);
    end
    r.scl_out  = mst_scl;
    r.sda_out  = mst_sda;
    r.busy_res = (mst_phase != PH_IDLE);
    r.done_res = fin;
    r.rx_byte  = mst_rx;
    r.nack     = mst_nack;
    return r;
  endfunction

  function automatic void master_reset();
    mst_phase   = PH_IDLE;
    mst_bit     = 4'd0;
    mst_shift   = 8'd0;
    mst_delay   = 8'd0;
    mst_polls   = 8'd0;
    mst_rx      = 8'd0;
    mst_ack_sel = 1'b0;
    mst_scl     = 1'b1;
    mst_sda     = 1'b1;
    mst_nack    = 1'b0;
    cfg_long    = LONG_DELAY_RESET;
    cfg_short   = SHORT_DELAY_RESET;
    cfg_limit   = POLL_LIMIT_RESET;
  endfunction

  // sda level for one tick under a per-command bias
  function automatic logic pick_sda(int bias);
    case (bias)
      0:       return 1'b1;
      1:       return 1'($urandom);
      default: return ($urandom_range(0, 7) != 0);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s at %0t ns: got %0h expected %0h", what, $time, got, want);
    mismatch_count++;
  endtask

  // offer one tick beat, wait for it to be taken, then predict its result
  task automatic send_tick(input logic [2:0] act, input logic [7:0] tx, input logic ack,
                           input logic sda, input logic lit, input i2cbm_res_t lit_res);
    i2cbm_res_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, sda, ack, tx, act};
    do @(posedge clk); while (!s_tready);
    if (mst_phase != PH_IDLE || (act >= ACT_START && act <= ACT_STOP))
      work_ticks++;
    r = master_tick(act, tx, ack, sda);
    predicted_q.push_back(lit ? lit_res : r);
  endtask

  // stop offering ticks and wait until every predicted beat has come out
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LONG_DELAY:  cfg_long  = val;
      CFG_SHORT_DELAY: cfg_short = val;
      CFG_POLL_LIMIT:  cfg_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one command tick, busy ticks with random content until it is done, then up to two idle ticks
  task automatic issue_cmd(input logic [2:0] act);
    int bias;
    bias = $urandom_range(0, 2);
    send_tick(act, 8'($urandom), 1'($urandom), pick_sda(bias), 1'b0, '0);
    while (mst_phase != PH_IDLE)
      send_tick(($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : ACT_NONE,
                8'($urandom), 1'($urandom), pick_sda(bias), 1'b0, '0);
    repeat ($urandom_range(0, 2))
      send_tick(ACT_NONE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
  endtask

  // one register setting: mostly well-formed transactions, some stray codes
  task automatic run_phase(input logic [7:0] lng, input logic [7:0] sht, input logic [7:0] lim,
                           input int snd_pct, input int rcv_pct, input int budget,
                           input bit hold_off, input bit pause);
    int start_ticks;
    bit quiet;
    settle();
    write_reg(CFG_LONG_DELAY, lng);
    write_reg(CFG_SHORT_DELAY, sht);
    write_reg(CFG_POLL_LIMIT, lim);
    start_ticks = work_ticks;
    while (work_ticks - start_ticks < budget) begin
      quiet         = ($urandom_range(0, 3) == 0);
      snd_idle_pct  = quiet ? 0 : snd_pct;
      rcv_stall_pct = quiet ? 0 : rcv_pct;
      if (!hold_off && $urandom_range(0, 9) == 0) begin
        issue_cmd(3'($urandom_range(0, 7)));
      end else begin
        issue_cmd(ACT_START);
        // long receiver hold-off while ticks keep coming
        if (hold_off) begin
          hold_req = 1'b1;
          hold_off = 1'b0;
        end
        repeat ($urandom_range(1, 3))
          issue_cmd($urandom_range(0, 1) ? ACT_WRITE : ACT_READ);
        issue_cmd(ACT_STOP);
      end
      // sender pause until the pipeline is empty
      if (pause && work_ticks - start_ticks >= budget / 2) begin
        settle();
        pause = 1'b0;
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
      end else begin
        m_tready = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = i2cbm_res_t'(m_tdata[12:0]);
      if (predicted_q.size() == 0) begin
        report_mismatch("beat with nothing expected", m_tdata[7:0], 8'h00);
      end else begin
        want_res = predicted_q.pop_front();
        if (m_tdata[15:13] != 3'b000)
          report_mismatch("pad bits", 8'(m_tdata[15:13]), 8'h00);
        if (seen_res.scl_out != want_res.scl_out)
          report_mismatch("scl_out", 8'(seen_res.scl_out), 8'(want_res.scl_out));
        if (seen_res.sda_out != want_res.sda_out)
          report_mismatch("sda_out", 8'(seen_res.sda_out), 8'(want_res.sda_out));
        if (seen_res.busy_res != want_res.busy_res)
          report_mismatch("busy_res", 8'(seen_res.busy_res), 8'(want_res.busy_res));
        if (seen_res.done_res != want_res.done_res)
          report_mismatch("done_res", 8'(seen_res.done_res), 8'(want_res.done_res));
        if (seen_res.rx_byte != want_res.rx_byte)
          report_mismatch("rx_byte", seen_res.rx_byte, want_res.rx_byte);
        if (seen_res.nack != want_res.nack)
          report_mismatch("nack", 8'(seen_res.nack), 8'(want_res.nack));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL i2c_bit_level_master_top");
    $finish;
  end

  // main sequence
  initial begin
    int row_i;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 16'h0000;
    cfg_valid = 1'b0;
    cfg_index = CFG_LONG_DELAY;
    cfg_data  = 8'h00;
    master_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table at reset register values
    for (row_i = 0; row_i < DIR_ROWS; row_i++) begin
      send_tick(DIR_TABLE[row_i].act, DIR_TABLE[row_i].tx, DIR_TABLE[row_i].ack,
                DIR_TABLE[row_i].sda, DIR_TABLE[row_i].lit, DIR_TABLE[row_i].res);
      while (mst_phase != PH_IDLE)
        send_tick(DIR_TABLE[row_i].fill_act, 8'($urandom), 1'($urandom),
                  DIR_TABLE[row_i].sda, 1'b0, '0);
    end

    // random phases: shortest holds, zero registers, stalls, largest poll limit
    run_phase(8'd1, 8'd1, 8'd1, 0, 0, PHASE_TICKS, 1'b0, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 77, 0, PHASE_TICKS, 1'b0, 1'b0);
    run_phase(8'($urandom_range(2, 6)), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
              0, 77, PHASE_TICKS, 1'b1, 1'b0);
    run_phase(8'($urandom_range(2, 6)), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
              17, 17, PHASE_TICKS, 1'b0, 1'b1);
    run_phase(8'd1, 8'd1, 8'd255, 0, 0, 1, 1'b0, 1'b0);

    settle();
    if (mismatch_count == 0)
      $display("PASS i2c_bit_level_master_top");
    else
      $display("FAIL i2c_bit_level_master_top");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_cfg.sv
rtl/core/i2cbm_seq.sv
rtl/core/i2c_bit_level_master_top.sv
tb/tb_i2c_bit_level_master_top.sv
